// ===== src/utf8_stream_decoder_core_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Checked at every rising clock edge outside of reset.
`define UTF8SD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define UTF8SD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== src/utf8sd_pkg.sv =====
package utf8sd_pkg;

    localparam int CP_W   = 31;
    localparam int BYTE_W = 8;
    localparam int ST_W   = 2;
    localparam int ADDR_W = 3;
    localparam int PART_W = 25;

    localparam logic [ST_W-1:0] ST_VALID   = 2'd0;
    localparam logic [ST_W-1:0] ST_INVALID = 2'd1;
    localparam logic [ST_W-1:0] ST_END     = 2'd2;

    localparam logic [ADDR_W-1:0] ADDR_REPL = 3'd0;
    localparam logic [CP_W-1:0]   REPL_RESET = 31'd63;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;
    localparam logic [2:0] LEN_5    = 3'd5;
    localparam logic [2:0] LEN_6    = 3'd6;

    // Checks a completed multi-byte value for overlong forms, surrogates
    // and the two non-characters at the end of the basic plane.
    function automatic logic value_ok(input logic [CP_W-1:0] v, input logic [2:0] len);
        logic [CP_W-1:0] floor_max;
        logic            ok;
        case (len)
            LEN_2:   floor_max = 31'h0000_007F;
            LEN_3:   floor_max = 31'h0000_07FF;
            LEN_4:   floor_max = 31'h0000_FFFF;
            LEN_5:   floor_max = 31'h001F_FFFF;
            LEN_6:   floor_max = 31'h03FF_FFFF;
            default: floor_max = '0;
        endcase
        ok = 1'b1;
        if (len >= LEN_2 && v <= floor_max) ok = 1'b0;
        if (v >= 31'h0000_D800 && v <= 31'h0000_DFFF) ok = 1'b0;
        if (v == 31'h0000_FFFE || v == 31'h0000_FFFF) ok = 1'b0;
        return ok;
    endfunction

endpackage

// ===== src/utf8_stream_decoder_core.sv =====
// UTF-8 stream decoder, original form with one- to six-byte sequences.
// Input channel (s_*): one word per raw byte in s_tdata; s_tlast high marks
// end of input, and the byte is then ignored. Result channel (m_*): the
// decoded code point in m_tdata and a status in m_tuser (valid, invalid
// sequence, or end of input). Lead bytes and non-final continuation bytes
// produce no result word. The APB port holds the replacement code that is
// sent for every invalid sequence; write it only while the block is idle.
// Throughput is one word per cycle while m_tready holds: the input register
// feeds a single pass of decode logic that updates the sequence state and
// loads the result register in the same cycle. Each input word is taken
// into the input register and then decoded into the result register on m_*.
// A stalled receiver holds the result register; the input register still
// takes one more word, after which s_tready drops until m_tready returns.
// Reset (synchronous, aresetn low) empties both registers, returns the
// decoder to idle and sets the replacement code back to '?' (63).
`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input channel
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [utf8sd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] byte_value
    input  logic                              s_tlast,   // end_of_stream
    // Result channel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,   // [30:0] code_point, [31] zero
    output logic [utf8sd_pkg::ST_W-1:0]       m_tuser,   // [1:0] status
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [utf8sd_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import utf8sd_pkg::*;

    // Configuration register.
    logic [CP_W-1:0] repl_reg;

    // Input register.
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;

    // Sequence state. The partial value never needs more than 25 bits
    // before the last continuation byte arrives.
    logic [PART_W-1:0] part_reg, part_next;
    logic [2:0]        rem_reg, rem_next;
    logic [2:0]        len_reg, len_next;

    // Result register.
    logic            out_valid_reg;
    logic [CP_W-1:0] out_cp_reg;
    logic [ST_W-1:0] out_st_reg;

    // Decode results for the word in the input register.
    logic            res_valid;
    logic [CP_W-1:0] res_cp;
    logic [ST_W-1:0] res_st;
    logic [CP_W-1:0] full_value;
    logic            adv;

    // The input word is decoded when the result register is free or being
    // emptied in this same cycle.
    assign adv      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || adv;

    assign full_value = {part_reg, in_byte_reg[5:0]};

    always_comb begin
        part_next = part_reg;
        rem_next  = rem_reg;
        len_next  = len_reg;
        res_valid = 1'b0;
        res_cp    = '0;
        res_st    = ST_VALID;

        if (in_eos_reg) begin
            // End of input drops any pending sequence.
            rem_next  = '0;
            len_next  = LEN_NONE;
            res_valid = 1'b1;
            res_st    = ST_END;
        end else if (rem_reg == 3'd0) begin
            if (!in_byte_reg[7]) begin
                res_valid = 1'b1;
                res_cp    = {{(CP_W-BYTE_W){1'b0}}, in_byte_reg};
            end else if (in_byte_reg[7:5] == 3'b110) begin
                part_next = {{(PART_W-5){1'b0}}, in_byte_reg[4:0]};
                len_next  = LEN_2;
                rem_next  = 3'd1;
            end else if (in_byte_reg[7:4] == 4'b1110) begin
                part_next = {{(PART_W-4){1'b0}}, in_byte_reg[3:0]};
                len_next  = LEN_3;
                rem_next  = 3'd2;
            end else if (in_byte_reg[7:3] == 5'b11110) begin
                part_next = {{(PART_W-3){1'b0}}, in_byte_reg[2:0]};
                len_next  = LEN_4;
                rem_next  = 3'd3;
            end else if (in_byte_reg[7:2] == 6'b111110) begin
                part_next = {{(PART_W-2){1'b0}}, in_byte_reg[1:0]};
                len_next  = LEN_5;
                rem_next  = 3'd4;
            end else if (in_byte_reg[7:1] == 7'b1111110) begin
                part_next = {{(PART_W-1){1'b0}}, in_byte_reg[0]};
                len_next  = LEN_6;
                rem_next  = 3'd5;
            end else begin
                // A stray continuation byte, 0xFE or 0xFF.
                res_valid = 1'b1;
                res_cp    = repl_reg;
                res_st    = ST_INVALID;
            end
        end else if (in_byte_reg[7:6] != 2'b10) begin
            // Expected a continuation; the offending byte is consumed.
            rem_next  = '0;
            len_next  = LEN_NONE;
            res_valid = 1'b1;
            res_cp    = repl_reg;
            res_st    = ST_INVALID;
        end else if (rem_reg == 3'd1) begin
            // Last continuation: check and emit the completed value.
            rem_next  = '0;
            len_next  = LEN_NONE;
            res_valid = 1'b1;
            if (value_ok(full_value, len_reg)) begin
                res_cp = full_value;
                res_st = ST_VALID;
            end else begin
                res_cp = repl_reg;
                res_st = ST_INVALID;
            end
        end else begin
            part_next = {part_reg[PART_W-7:0], in_byte_reg[5:0]};
            rem_next  = rem_reg - 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready) begin
            in_byte_reg <= s_tdata;
            in_eos_reg  <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            len_reg <= LEN_NONE;
        end else if (adv) begin
            rem_reg <= rem_next;
            len_reg <= len_next;
        end
        if (adv) begin
            part_reg <= part_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= res_valid;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (adv) begin
            out_cp_reg <= res_cp;
            out_st_reg <= res_st;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_cp_reg};
    assign m_tuser  = out_st_reg;

    // Configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_reg <= REPL_RESET;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_REPL) begin
            repl_reg <= pwdata[CP_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_REPL) ? {1'b0, repl_reg} : 32'd0;

    // Checks on the sequence state and the result register.
    `UTF8SD_ASSERT(a_rem_below_len, rem_reg != 3'd0 |-> (rem_reg < len_reg && rem_reg <= 3'd5), "continuation count out of step with sequence length")
    `UTF8SD_ASSERT(a_eos_goes_idle, adv && in_eos_reg |=> rem_reg == 3'd0 && len_reg == LEN_NONE, "end marker did not return the decoder to idle")
    `UTF8SD_ASSERT(a_end_is_zero, out_valid_reg && out_st_reg == ST_END |-> out_cp_reg == '0, "end status with a nonzero code point")
    `UTF8SD_ASSERT(a_status_known, out_valid_reg |-> out_st_reg != 2'd3, "result status outside the defined codes")

endmodule
